[sv/tbba_pkg.sv]
package tbba_pkg;

  localparam int CoordWidth    = 32;
  localparam int FracBits      = 16;
  localparam int NumAxes       = 3;
  localparam int AxisWidth     = 2;
  localparam int ProdWidth     = 2 * CoordWidth;
  localparam int TermWidth     = ProdWidth - FracBits;
  localparam int SumWidth      = TermWidth + 2;
  localparam int DataWidth     = 32;
  localparam int AddrWidth     = 5;
  localparam int RegIndexWidth = AddrWidth - 2;

  localparam logic [AxisWidth-1:0] AxisNone = 2'd3;

  localparam logic [RegIndexWidth-1:0] RegLocalMinX = 3'd0;
  localparam logic [RegIndexWidth-1:0] RegLocalMinY = 3'd1;
  localparam logic [RegIndexWidth-1:0] RegLocalMinZ = 3'd2;
  localparam logic [RegIndexWidth-1:0] RegLocalMaxX = 3'd3;
  localparam logic [RegIndexWidth-1:0] RegLocalMaxY = 3'd4;
  localparam logic [RegIndexWidth-1:0] RegLocalMaxZ = 3'd5;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t [NumAxes-1:0] lo;
    coord_t [NumAxes-1:0] hi;
  } box_t;

  typedef struct packed {
    logic [AxisWidth-1:0] axis;
    coord_t [NumAxes-1:0] coef;
    coord_t               offset;
    logic                 start;
    logic                 contribute;
  } row_t;

endpackage

[sv/tbba_front.sv]
module tbba_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tbba_pkg::AddrWidth-1:0] paddr,
  input  logic [tbba_pkg::DataWidth-1:0] pwdata,
  output logic [tbba_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tbba_pkg::AxisWidth-1:0] axis_i,
  input  tbba_pkg::coord_t               coef_x_i,
  input  tbba_pkg::coord_t               coef_y_i,
  input  tbba_pkg::coord_t               coef_z_i,
  input  tbba_pkg::coord_t               offset_i,
  input  logic                           start_new_i,
  output logic                           q_push_o,
  output tbba_pkg::row_t                 q_row_o,
  input  logic                           q_full_i,
  output tbba_pkg::box_t                 box_o
);
  import tbba_pkg::*;

  box_t                     box_q;
  logic [RegIndexWidth-1:0] reg_idx;
  logic                     wr_en;
  logic                     box_ok;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrWidth-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegLocalMinX: box_q.lo[0] <= pwdata;
        RegLocalMinY: box_q.lo[1] <= pwdata;
        RegLocalMinZ: box_q.lo[2] <= pwdata;
        RegLocalMaxX: box_q.hi[0] <= pwdata;
        RegLocalMaxY: box_q.hi[1] <= pwdata;
        RegLocalMaxZ: box_q.hi[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegLocalMinX: prdata = box_q.lo[0];
      RegLocalMinY: prdata = box_q.lo[1];
      RegLocalMinZ: prdata = box_q.lo[2];
      RegLocalMaxX: prdata = box_q.hi[0];
      RegLocalMaxY: prdata = box_q.hi[1];
      RegLocalMaxZ: prdata = box_q.hi[2];
      default:      prdata = '0;
    endcase
  end

  // an inverted box contributes no corners
  always_comb begin
    box_ok = 1'b1;
    for (int i = 0; i < NumAxes; i++) begin
      if ($signed(box_q.lo[i]) > $signed(box_q.hi[i])) box_ok = 1'b0;
    end
  end

  assign box_o              = box_q;
  assign in_ready_o         = !q_full_i;
  assign q_push_o           = in_valid_i;
  assign q_row_o.axis       = axis_i;
  assign q_row_o.coef[0]    = coef_x_i;
  assign q_row_o.coef[1]    = coef_y_i;
  assign q_row_o.coef[2]    = coef_z_i;
  assign q_row_o.offset     = offset_i;
  assign q_row_o.start      = start_new_i;
  assign q_row_o.contribute = box_ok && (axis_i != AxisNone);

endmodule

[sv/tbba_queue.sv]
module tbba_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tbba_pkg::row_t row_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tbba_pkg::row_t row_o
);
  import tbba_pkg::*;

  localparam int Depth    = 2;
  localparam int PtrWidth = $clog2(Depth);
  localparam int CntWidth = $clog2(Depth + 1);

  row_t                mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                push_ok;
  logic                pop_ok;

  assign full_o  = (count_q == CntWidth'(Depth));
  assign valid_o = (count_q != '0);
  assign row_o   = mem_q[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= row_i;
    end
  end

endmodule

[sv/tbba_back.sv]
module tbba_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  tbba_pkg::row_t                 q_row_i,
  output logic                           q_pop_o,
  input  tbba_pkg::box_t                 box_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tbba_pkg::AxisWidth-1:0] axis_out_o,
  output tbba_pkg::coord_t               bound_min_o,
  output tbba_pkg::coord_t               bound_max_o,
  output logic                           bounds_valid_o
);
  import tbba_pkg::*;

  typedef struct packed {
    logic [AxisWidth-1:0] axis;
    coord_t               offset;
    logic                 start;
    logic                 contribute;
  } meta_t;

  function automatic coord_t sat_coord(input logic signed [SumWidth-1:0] v);
    coord_t r;
    if ((&v[SumWidth-1:CoordWidth-1]) || !(|v[SumWidth-1:CoordWidth-1])) begin
      r = v[CoordWidth-1:0];
    end else if (v[SumWidth-1]) begin
      r = {1'b1, {(CoordWidth-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordWidth-1){1'b1}}};
    end
    return r;
  endfunction

  logic adv;

  // multiply stage
  logic                        s1_valid_q;
  meta_t                       s1_meta_q;
  logic signed [ProdWidth-1:0] prod_lo_q [NumAxes];
  logic signed [ProdWidth-1:0] prod_hi_q [NumAxes];

  // term select stage
  logic                        s2_valid_q;
  meta_t                       s2_meta_q;
  logic signed [TermWidth-1:0] term_min_q [NumAxes];
  logic signed [TermWidth-1:0] term_max_q [NumAxes];
  logic signed [TermWidth-1:0] term_min_d [NumAxes];
  logic signed [TermWidth-1:0] term_max_d [NumAxes];
  logic signed [ProdWidth-1:0] shift_lo   [NumAxes];
  logic signed [ProdWidth-1:0] shift_hi   [NumAxes];

  // sum stage
  logic                        s3_valid_q;
  meta_t                       s3_meta_q;
  coord_t                      mn_q;
  coord_t                      mx_q;
  logic signed [SumWidth-1:0]  sum_lo;
  logic signed [SumWidth-1:0]  sum_hi;

  // accumulator and result
  coord_t                      acc_min_q [NumAxes];
  coord_t                      acc_max_q [NumAxes];
  logic [NumAxes-1:0]          acc_has_q;
  coord_t                      min_n;
  coord_t                      max_n;
  logic                        has_n;
  logic                        acc_we;
  logic                        out_valid_q;
  logic [AxisWidth-1:0]        axis_out_q;
  coord_t                      bound_min_q;
  coord_t                      bound_max_q;
  logic                        bounds_valid_q;

  assign adv     = !out_valid_q || out_ready_i;
  assign q_pop_o = adv && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_meta_q.axis       <= q_row_i.axis;
      s1_meta_q.offset     <= q_row_i.offset;
      s1_meta_q.start      <= q_row_i.start;
      s1_meta_q.contribute <= q_row_i.contribute;
      for (int i = 0; i < NumAxes; i++) begin
        prod_lo_q[i] <= $signed(q_row_i.coef[i]) * $signed(box_i.lo[i]);
        prod_hi_q[i] <= $signed(q_row_i.coef[i]) * $signed(box_i.hi[i]);
      end
    end
  end

  // floor of the scaled product, then per-coefficient min and max
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      shift_lo[i] = prod_lo_q[i] >>> FracBits;
      shift_hi[i] = prod_hi_q[i] >>> FracBits;
      if (shift_lo[i] < shift_hi[i]) begin
        term_min_d[i] = shift_lo[i][TermWidth-1:0];
        term_max_d[i] = shift_hi[i][TermWidth-1:0];
      end else begin
        term_min_d[i] = shift_hi[i][TermWidth-1:0];
        term_max_d[i] = shift_lo[i][TermWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_meta_q <= s1_meta_q;
      for (int i = 0; i < NumAxes; i++) begin
        term_min_q[i] <= term_min_d[i];
        term_max_q[i] <= term_max_d[i];
      end
    end
  end

  assign sum_lo = SumWidth'($signed(s2_meta_q.offset)) + SumWidth'(term_min_q[0])
                + SumWidth'(term_min_q[1]) + SumWidth'(term_min_q[2]);
  assign sum_hi = SumWidth'($signed(s2_meta_q.offset)) + SumWidth'(term_max_q[0])
                + SumWidth'(term_max_q[1]) + SumWidth'(term_max_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_meta_q <= s2_meta_q;
      mn_q      <= sat_coord(sum_lo);
      mx_q      <= sat_coord(sum_hi);
    end
  end

  always_comb begin
    has_n = 1'b0;
    min_n = '0;
    max_n = '0;
    if (s3_meta_q.axis != AxisNone) begin
      has_n = acc_has_q[s3_meta_q.axis];
      min_n = acc_min_q[s3_meta_q.axis];
      max_n = acc_max_q[s3_meta_q.axis];
      if (s3_meta_q.start) begin
        has_n = 1'b0;
        min_n = '0;
        max_n = '0;
      end
      if (s3_meta_q.contribute) begin
        if (!has_n) begin
          min_n = mn_q;
          max_n = mx_q;
        end else begin
          if (mn_q < min_n) min_n = mn_q;
          if (mx_q > max_n) max_n = mx_q;
        end
        has_n = 1'b1;
      end
    end
  end

  assign acc_we = adv && s3_valid_q && (s3_meta_q.axis != AxisNone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_has_q <= '0;
      for (int i = 0; i < NumAxes; i++) begin
        acc_min_q[i] <= '0;
        acc_max_q[i] <= '0;
      end
    end else if (acc_we) begin
      acc_has_q[s3_meta_q.axis] <= has_n;
      acc_min_q[s3_meta_q.axis] <= min_n;
      acc_max_q[s3_meta_q.axis] <= max_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_valid_q) begin
      axis_out_q     <= s3_meta_q.axis;
      bound_min_q    <= min_n;
      bound_max_q    <= max_n;
      bounds_valid_q <= has_n;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign axis_out_o     = axis_out_q;
  assign bound_min_o    = bound_min_q;
  assign bound_max_o    = bound_max_q;
  assign bounds_valid_o = bounds_valid_q;

endmodule

[sv/transformed_box_bounds_accumulator_core.sv]
// Transformed box bounds accumulator. Each request is one affine matrix row
// for one axis; the block transforms the configured local box by it and
// widens that axis's running min/max (signed Q16.16, saturated), returning
// the axis bounds after the update. One request per cycle is sustained unless
// the output stalls; a result passes through a two-entry queue, a multiply
// stage with six 32x32 multipliers, a term select stage, a sum and saturate
// stage, then the accumulator update into the output register. A row with
// axis three changes nothing and returns zero bounds. Box registers at byte
// addresses 0x00..0x14, written by the user only while idle (not enforced).
module transformed_box_bounds_accumulator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tbba_pkg::AddrWidth-1:0] paddr,
  input  logic [tbba_pkg::DataWidth-1:0] pwdata,
  output logic [tbba_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tbba_pkg::AxisWidth-1:0] axis_i,
  input  tbba_pkg::coord_t               coef_x_i,
  input  tbba_pkg::coord_t               coef_y_i,
  input  tbba_pkg::coord_t               coef_z_i,
  input  tbba_pkg::coord_t               offset_i,
  input  logic                           start_new_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tbba_pkg::AxisWidth-1:0] axis_out_o,
  output tbba_pkg::coord_t               bound_min_o,
  output tbba_pkg::coord_t               bound_max_o,
  output logic                           bounds_valid_o
);
  import tbba_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  row_t q_row_in;
  row_t q_row_out;
  box_t box;

  tbba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .axis_i      (axis_i),
    .coef_x_i    (coef_x_i),
    .coef_y_i    (coef_y_i),
    .coef_z_i    (coef_z_i),
    .offset_i    (offset_i),
    .start_new_i (start_new_i),
    .q_push_o    (q_push),
    .q_row_o     (q_row_in),
    .q_full_i    (q_full),
    .box_o       (box)
  );

  tbba_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .row_i   (q_row_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .row_o   (q_row_out)
  );

  tbba_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_row_i        (q_row_out),
    .q_pop_o        (q_pop),
    .box_i          (box),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .axis_out_o     (axis_out_o),
    .bound_min_o    (bound_min_o),
    .bound_max_o    (bound_max_o),
    .bounds_valid_o (bounds_valid_o)
  );

endmodule

[sv/tbba_checker.sv]
module tbba_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [tbba_pkg::AxisWidth-1:0] axis_out_o,
  input tbba_pkg::coord_t               bound_min_o,
  input tbba_pkg::coord_t               bound_max_o,
  input logic                           bounds_valid_o
);
  import tbba_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(axis_out_o)
      && $stable(bound_min_o) && $stable(bound_max_o) && $stable(bounds_valid_o))
    else $error("result changed while stalled");

  a_ignored_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && axis_out_o == AxisNone |->
      bound_min_o == '0 && bound_max_o == '0 && !bounds_valid_o)
    else $error("ignored axis reported bounds");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bounds_valid_o |-> bound_min_o == '0 && bound_max_o == '0)
    else $error("axis without bounds reported nonzero bounds");

  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bounds_valid_o |-> $signed(bound_min_o) <= $signed(bound_max_o))
    else $error("minimum above maximum");

endmodule

bind transformed_box_bounds_accumulator_core tbba_checker u_tbba_checker (.*);

[tb/sv/transformed_box_bounds_accumulator_core_test.sv]
module transformed_box_bounds_accumulator_core_test;
  import tbba_pkg::*;

  localparam int HoldCycles   = 90;
  localparam int RandomPhases = 8;
  localparam int PhaseItems   = 200;

  localparam logic [AxisWidth-1:0] AxisX = 2'd0;
  localparam logic [AxisWidth-1:0] AxisY = 2'd1;
  localparam logic [AxisWidth-1:0] AxisZ = 2'd2;

  localparam coord_t CoordMax  = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam coord_t CoordMin  = {1'b1, {(CoordWidth-1){1'b0}}};
  localparam coord_t OneQ      = coord_t'(1) <<< FracBits;
  localparam longint TermLimit = longint'(1) <<< 60;

  typedef enum int {BoxSmall, BoxFull, BoxExtreme, BoxInverted} box_mode_e;

  typedef struct packed {
    logic [AxisWidth-1:0] axis;
    coord_t               coef_x;
    coord_t               coef_y;
    coord_t               coef_z;
    coord_t               offset;
    logic                 start_new;
  } row_req_t;

  typedef struct packed {
    logic [AxisWidth-1:0] axis;
    coord_t               bound_min;
    coord_t               bound_max;
    logic                 valid;
  } bounds_t;

  class bounds_scoreboard;
    coord_t  box_lo [NumAxes];
    coord_t  box_hi [NumAxes];
    coord_t  acc_min [NumAxes];
    coord_t  acc_max [NumAxes];
    bit      acc_has [NumAxes];
    bounds_t expected_q [$];
    int      errors;

    function new();
      int i;
      for (i = 0; i < NumAxes; i++) begin
        box_lo[i] = '0;
        box_hi[i] = '0;
        acc_min[i] = '0;
        acc_max[i] = '0;
        acc_has[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function void set_edge(logic [RegIndexWidth-1:0] idx, coord_t v);
      case (idx)
        RegLocalMinX: box_lo[0] = v;
        RegLocalMinY: box_lo[1] = v;
        RegLocalMinZ: box_lo[2] = v;
        RegLocalMaxX: box_hi[0] = v;
        RegLocalMaxY: box_hi[1] = v;
        RegLocalMaxZ: box_hi[2] = v;
        default: ;
      endcase
    endfunction

    function void queue_expected(bounds_t e);
      expected_q = {expected_q, e};
    endfunction

    // floor of the Q16.16 product, clamped to +-2^60
    function longint scaled_product(coord_t a, coord_t b);
      longint p;
      p = (longint'(a) * longint'(b)) >>> FracBits;
      if (p > TermLimit)
        p = TermLimit;
      else if (p < -TermLimit)
        p = -TermLimit;
      return p;
    endfunction

    function coord_t clamp_coord(longint v);
      if (v > longint'(CoordMax))
        return CoordMax;
      if (v < longint'(CoordMin))
        return CoordMin;
      return coord_t'(v);
    endfunction

    function void note_request(row_req_t r);
      bounds_t e;
      coord_t  coefs [NumAxes];
      longint  lo_sum, hi_sum, p, q;
      coord_t  mn, mx;
      bit      box_ok;
      int      ax, i;
      e = '0;
      e.axis = r.axis;
      if (r.axis == AxisNone) begin
        queue_expected(e);
        return;
      end
      ax = r.axis;
      coefs[0] = r.coef_x;
      coefs[1] = r.coef_y;
      coefs[2] = r.coef_z;
      lo_sum = longint'(r.offset);
      hi_sum = lo_sum;
      if (r.start_new) begin
        acc_has[ax] = 1'b0;
        acc_min[ax] = '0;
        acc_max[ax] = '0;
      end
      box_ok = 1'b1;
      for (i = 0; i < NumAxes; i++)
        if (box_lo[i] > box_hi[i])
          box_ok = 1'b0;
      if (box_ok) begin
        for (i = 0; i < NumAxes; i++) begin
          p = scaled_product(coefs[i], box_lo[i]);
          q = scaled_product(coefs[i], box_hi[i]);
          lo_sum += (p < q) ? p : q;
          hi_sum += (p < q) ? q : p;
        end
        mn = clamp_coord(lo_sum);
        mx = clamp_coord(hi_sum);
        if (!acc_has[ax]) begin
          acc_min[ax] = mn;
          acc_max[ax] = mx;
          acc_has[ax] = 1'b1;
        end else begin
          if (mn < acc_min[ax])
            acc_min[ax] = mn;
          if (mx > acc_max[ax])
            acc_max[ax] = mx;
        end
      end
      e.bound_min = acc_min[ax];
      e.bound_max = acc_max[ax];
      e.valid = acc_has[ax];
      queue_expected(e);
    endfunction

    function void report(string field, longint want, longint seen);
      errors++;
      $error("%s: expected %0d, got %0d", field, want, seen);
    endfunction

    function void check_result(bounds_t got);
      bounds_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $error("unexpected result on axis %0d", got.axis);
        return;
      end
      e = expected_q.pop_front();
      if (got.axis !== e.axis)
        report("axis_out", e.axis, got.axis);
      if (got.bound_min !== e.bound_min)
        report("bound_min", $signed(e.bound_min), $signed(got.bound_min));
      if (got.bound_max !== e.bound_max)
        report("bound_max", $signed(e.bound_max), $signed(got.bound_max));
      if (got.valid !== e.valid)
        report("bounds_valid", e.valid, got.valid);
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [AddrWidth-1:0]     paddr;
  logic [DataWidth-1:0]     pwdata;
  logic [DataWidth-1:0]     prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [AxisWidth-1:0]     axis_i;
  coord_t                   coef_x_i;
  coord_t                   coef_y_i;
  coord_t                   coef_z_i;
  coord_t                   offset_i;
  logic                     start_new_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [AxisWidth-1:0]     axis_out_o;
  coord_t                   bound_min_o;
  coord_t                   bound_max_o;
  logic                     bounds_valid_o;

  bounds_scoreboard sb;
  bit               burst;
  bit               hold_output;
  box_mode_e        phase_mode [RandomPhases] = '{BoxSmall, BoxFull, BoxSmall, BoxExtreme,
                                                  BoxInverted, BoxFull, BoxSmall, BoxSmall};

  transformed_box_bounds_accumulator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .axis_i         (axis_i),
    .coef_x_i       (coef_x_i),
    .coef_y_i       (coef_y_i),
    .coef_z_i       (coef_z_i),
    .offset_i       (offset_i),
    .start_new_i    (start_new_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .axis_out_o     (axis_out_o),
    .bound_min_o    (bound_min_o),
    .bound_max_o    (bound_max_o),
    .bounds_valid_o (bounds_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20 * 300000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic row_req_t mk_row(logic [AxisWidth-1:0] axis, coord_t cx, coord_t cy,
                                      coord_t cz, coord_t off, logic start);
    row_req_t r;
    r.axis = axis;
    r.coef_x = cx;
    r.coef_y = cy;
    r.coef_z = cz;
    r.offset = off;
    r.start_new = start;
    return r;
  endfunction

  function automatic coord_t small_coord();
    return coord_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return small_coord();
      5, 6, 7: return coord_t'($urandom);
      8: begin
        case ($urandom_range(0, 3))
          0: return CoordMax;
          1: return CoordMin;
          2: return '0;
          default: return OneQ;
        endcase
      end
      default: return coord_t'(($signed($urandom_range(0, 8)) - 4) * (1 << FracBits));
    endcase
  endfunction

  function automatic row_req_t random_row(logic [AxisWidth-1:0] axis);
    return mk_row(axis, random_coord(), random_coord(), random_coord(), random_coord(), 1'b0);
  endfunction

  function automatic box_t random_box(box_mode_e mode);
    box_t   b;
    coord_t lo, hi, t;
    int     i;
    for (i = 0; i < NumAxes; i++) begin
      case (mode)
        BoxFull: begin
          lo = coord_t'($urandom);
          hi = coord_t'($urandom);
        end
        BoxExtreme: begin
          lo = CoordMin;
          hi = CoordMax;
        end
        default: begin
          lo = small_coord();
          hi = small_coord();
        end
      endcase
      if (lo > hi) begin
        t = lo;
        lo = hi;
        hi = t;
      end
      b.lo[i] = lo;
      b.hi[i] = hi;
    end
    if (mode == BoxInverted) begin
      i = $urandom_range(0, NumAxes - 1);
      b.lo[i] = OneQ;
      b.hi[i] = -OneQ;
    end
    return b;
  endfunction

  task automatic write_edge(logic [RegIndexWidth-1:0] idx, coord_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_edge(idx, value);
  endtask

  task automatic write_box(box_t b);
    write_edge(RegLocalMinX, b.lo[0]);
    write_edge(RegLocalMinY, b.lo[1]);
    write_edge(RegLocalMinZ, b.lo[2]);
    write_edge(RegLocalMaxX, b.hi[0]);
    write_edge(RegLocalMaxY, b.hi[1]);
    write_edge(RegLocalMaxZ, b.hi[2]);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_row(row_req_t r);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    axis_i <= r.axis;
    coef_x_i <= r.coef_x;
    coef_y_i <= r.coef_y;
    coef_z_i <= r.coef_z;
    offset_i <= r.offset;
    start_new_i <= r.start_new;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(r);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // runs of three-row instances, the first mostly opened by a start flag, plus stray rows
  task automatic run_random_phase(int count);
    row_req_t r;
    int       sent, groups, g, a;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        r = random_row(AxisWidth'($urandom_range(0, 3)));
        r.start_new = 1'($urandom_range(0, 1));
        send_row(r);
        sent++;
      end else begin
        groups = $urandom_range(1, 5);
        for (g = 0; g < groups; g++) begin
          for (a = 0; a < NumAxes; a++) begin
            r = random_row(AxisWidth'(a));
            r.start_new = (g == 0) && ($urandom_range(0, 7) != 0);
            send_row(r);
            sent++;
          end
        end
      end
    end
  endtask

  // result side
  initial begin
    bounds_t got;
    int      gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_output) begin
        gap = HoldCycles;
        hold_output = 1'b0;
      end else begin
        gap = burst ? 0 : $urandom_range(0, 7);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_ready_i === 1'b1));
      got.axis = axis_out_o;
      got.bound_min = bound_min_o;
      got.bound_max = bound_max_o;
      got.valid = bounds_valid_o;
      sb.check_result(got);
    end
  end

  initial begin
    box_t b;
    int   ph, i;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    axis_i <= '0;
    coef_x_i <= '0;
    coef_y_i <= '0;
    coef_z_i <= '0;
    offset_i <= '0;
    start_new_i <= 1'b0;
    burst = 1'b0;
    hold_output = 1'b0;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero box after reset: bounds collapse to the offset
    send_row(mk_row(AxisX, CoordMax, CoordMin, '0, 32'sh1234_5678, 1'b1));
    send_row(mk_row(AxisNone, CoordMax, CoordMax, CoordMax, CoordMax, 1'b1));
    send_row(mk_row(AxisY, '0, '0, '0, CoordMin, 1'b0));

    // full range box, saturation and floor rounding
    drain_results();
    write_box(random_box(BoxExtreme));
    send_row(mk_row(AxisX, CoordMax, CoordMax, CoordMax, CoordMax, 1'b1));
    send_row(mk_row(AxisY, CoordMin, CoordMin, CoordMin, CoordMin, 1'b1));
    send_row(mk_row(AxisZ, 32'sd1, -32'sd1, '0, '0, 1'b1));
    send_row(mk_row(AxisZ, '0, '0, '0, CoordMax, 1'b0));
    send_row(mk_row(AxisZ, '0, '0, '0, CoordMin, 1'b0));
    send_row(mk_row(AxisX, OneQ, '0, '0, '0, 1'b1));

    // inverted y edge: nothing included, start still clears
    drain_results();
    b.lo[0] = -OneQ;
    b.hi[0] = OneQ;
    b.lo[1] = OneQ;
    b.hi[1] = -OneQ;
    b.lo[2] = -OneQ;
    b.hi[2] = OneQ;
    write_box(b);
    send_row(mk_row(AxisX, CoordMax, OneQ, '0, '0, 1'b0));
    send_row(mk_row(AxisX, CoordMax, OneQ, '0, '0, 1'b1));
    send_row(mk_row(AxisY, OneQ, OneQ, OneQ, OneQ, 1'b0));
    send_row(mk_row(AxisNone, '0, '0, '0, '0, 1'b0));

    // box from -1.0 to 1.5 with fractional coefficients
    drain_results();
    for (i = 0; i < NumAxes; i++) begin
      b.lo[i] = 32'shFFFF_0000;
      b.hi[i] = 32'sh0001_8000;
    end
    write_box(b);
    send_row(mk_row(AxisX, -32'sd1, 32'sd3, -32'sd3, '0, 1'b1));
    send_row(mk_row(AxisY, 32'sh0000_8000, -32'sh0000_8000, CoordMax, CoordMin, 1'b1));
    send_row(mk_row(AxisZ, CoordMin, CoordMax, 32'sd1, CoordMax, 1'b1));
    send_row(mk_row(AxisX, '0, '0, '0, '0, 1'b0));
    send_row(mk_row(AxisY, 32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000,
                    32'sh7FFF_0000, 1'b0));

    for (ph = 0; ph < RandomPhases; ph++) begin
      drain_results();
      write_box(random_box(phase_mode[ph]));
      burst = (ph == 2) || (ph == 5);
      hold_output = (ph == 2);
      run_random_phase(PhaseItems);
    end
    drain_results();

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
